// ----- rtl/srsw_pkg.sv -----
// Shared types and constants of the selective repeat sender window.
`timescale 1ns / 1ps

package srsw_pkg;

    // Sequence space: eight numbers, three bits wide
    localparam int SEQ_COUNT = 8;
    localparam int SEQ_W     = 3;
    localparam int WSIZE_W   = 3;

    // Window size after reset
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 3'd4;

    // Item kinds carried on the input tuser
    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Command from the sequencer to the window tracker
    typedef struct packed {
        logic             apply;
        logic [1:0]       op;
        logic [SEQ_W-1:0] ack_num;
        logic             ack_ok;
    } win_cmd_t;

    // Status from the window tracker: send permission and post-update values
    typedef struct packed {
        logic             can_send;
        logic [SEQ_W-1:0] base_next;
        logic [SEQ_W-1:0] next_seq_next;
        logic             full_next;
    } win_stat_t;

endpackage

// ----- rtl/srsw_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module srsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/srsw_window.sv -----
// Window tracker: base, next number, acknowledged marks and window size.
`timescale 1ns / 1ps

module srsw_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [srsw_pkg::WSIZE_W-1:0]   cfg_data,
    input  srsw_pkg::win_cmd_t             cmd,
    output srsw_pkg::win_stat_t            stat
);

    import srsw_pkg::*;

    logic [WSIZE_W-1:0]   wsize_reg;
    logic [SEQ_W-1:0]     base_reg;
    logic [SEQ_W-1:0]     base_next;
    logic [SEQ_W-1:0]     next_reg;
    logic [SEQ_W-1:0]     next_next;
    logic [SEQ_COUNT-1:0] mark_reg;
    logic [SEQ_COUNT-1:0] mark_next;

    logic [WSIZE_W-1:0]   eff_win;
    logic [SEQ_W-1:0]     outst;
    logic                 full_now;
    logic                 ack_in_win;
    logic [SEQ_COUNT-1:0] marked;
    logic [SEQ_COUNT-1:0] rot;
    logic [SEQ_W:0]       run_len;
    logic                 run_on;
    logic [SEQ_W-1:0]     new_outst;

    // Clamp the window to 1 .. SEQ_COUNT-1
    always_comb
    begin
        eff_win = wsize_reg;
        if (wsize_reg == '0)
        begin
            eff_win = WSIZE_W'(1);
        end
        else if (wsize_reg > WSIZE_W'(SEQ_COUNT - 1))
        begin
            eff_win = WSIZE_W'(SEQ_COUNT - 1);
        end
    end

    // Outstanding count wraps naturally as the sequence space is a power of two
    assign outst      = next_reg - base_reg;
    assign full_now   = outst >= eff_win;
    assign ack_in_win = (cmd.ack_num - base_reg) < outst;

    // Mark the acknowledged number, then slide the base past the run of marks
    always_comb
    begin
        marked = mark_reg | (SEQ_COUNT'(1) << cmd.ack_num);
        for (int i = 0; i < SEQ_COUNT; i++)
        begin
            rot[i] = marked[SEQ_W'(base_reg + SEQ_W'(i))];
        end
        run_len = '0;
        run_on  = 1'b1;
        for (int i = 0; i < SEQ_COUNT; i++)
        begin
            if (run_on && rot[i])
            begin
                run_len = run_len + 1'b1;
            end
            else
            begin
                run_on = 1'b0;
            end
        end
    end

    // Next state of the window
    always_comb
    begin
        base_next = base_reg;
        next_next = next_reg;
        mark_next = mark_reg;
        if (cmd.apply)
        begin
            case (cmd.op)
                OP_SEND:
                begin
                    if (!full_now)
                    begin
                        mark_next[next_reg] = 1'b0;
                        next_next           = next_reg + 1'b1;
                    end
                end
                OP_ACK:
                begin
                    if (cmd.ack_ok && ack_in_win)
                    begin
                        mark_next = marked;
                        for (int i = 0; i < SEQ_COUNT; i++)
                        begin
                            if ((SEQ_W+1)'(i) < run_len)
                            begin
                                mark_next[SEQ_W'(base_reg + SEQ_W'(i))] = 1'b0;
                            end
                        end
                        base_next = base_reg + run_len[SEQ_W-1:0];
                    end
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    assign new_outst = next_next - base_next;

    assign stat.can_send      = !full_now;
    assign stat.base_next     = base_next;
    assign stat.next_seq_next = next_next;
    assign stat.full_next     = new_outst >= eff_win;

    // Hold the window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg <= WSIZE_RESET;
            base_reg  <= '0;
            next_reg  <= '0;
            mark_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                wsize_reg <= cfg_data;
            end
            base_reg <= base_next;
            next_reg <= next_next;
            mark_reg <= mark_next;
        end
    end

endmodule

// ----- rtl/selective_repeat_sender_window_unit.sv -----
// An accepted input item is captured in the input registers and the payload store
// is read; the result is loaded into the result register once that is empty or
// taken, and only then is a new item accepted. Reset: control, window base, next
// number and marks clear, window size is 4; the payload store is not cleared, and
// the user must see an entry read only after a send wrote it; no check enforces it.
`timescale 1ns / 1ps

module selective_repeat_sender_window_unit #(
    parameter int PAYLOAD_BITS = 64
) (
    input  logic clk,
    input  logic rst_n,
    // Configuration: window size
    input  logic                                   cfg_we,
    input  logic [srsw_pkg::WSIZE_W-1:0]           cfg_data,
    // Input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // payload, ack_num, ack_ok, timeout_seq, zero fill
    input  logic [((PAYLOAD_BITS+7+7)/8)*8-1:0]    s_tdata,
    // op
    input  logic [1:0]                             s_tuser,
    // Result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // accepted, pkt_valid, pkt_seq, pkt_payload, timer_start, timer_stop,
    // timer_seq, window_base, next_seq, window_full, zero fill
    output logic [((PAYLOAD_BITS+17+7)/8)*8-1:0]   m_tdata
);

    import srsw_pkg::*;

    localparam int OUT_W = ((PAYLOAD_BITS + 17 + 7) / 8) * 8;
    localparam int USED_W = PAYLOAD_BITS + 17;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]              op_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [SEQ_W-1:0]        ack_num_reg;
    logic                    ack_ok_reg;
    logic [SEQ_W-1:0]        tseq_reg;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic [USED_W-1:0]       res;

    logic                    in_fire;
    logic                    exec_go;
    logic                    ram_we;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    win_cmd_t                cmd;
    win_stat_t               stat;

    logic                    r_acc, r_pv, r_tstart, r_tstop;
    logic [SEQ_W-1:0]        r_pseq, r_tseq;
    logic [PAYLOAD_BITS-1:0] r_ppay;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Capture the input item fields
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= s_tuser;
            payload_reg <= s_tdata[PAYLOAD_BITS-1:0];
            ack_num_reg <= s_tdata[PAYLOAD_BITS+2:PAYLOAD_BITS];
            ack_ok_reg  <= s_tdata[PAYLOAD_BITS+3];
            tseq_reg    <= s_tdata[PAYLOAD_BITS+6:PAYLOAD_BITS+4];
        end
    end

    // Window tracker
    assign cmd.apply   = exec_go;
    assign cmd.op      = op_reg;
    assign cmd.ack_num = ack_num_reg;
    assign cmd.ack_ok  = ack_ok_reg;

    srsw_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Payload store: write on an accepted send, read on every input item
    assign ram_we = exec_go && (op_reg == OP_SEND) && stat.can_send;

    srsw_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SEQ_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (stat.next_seq_next - 1'b1),
        .wdata (payload_reg),
        .re    (in_fire),
        .raddr (s_tdata[PAYLOAD_BITS+6:PAYLOAD_BITS+4]),
        .rdata (ram_rdata)
    );

    // Form the result item
    always_comb
    begin
        r_acc    = 1'b0;
        r_pv     = 1'b0;
        r_pseq   = '0;
        r_ppay   = '0;
        r_tstart = 1'b0;
        r_tstop  = 1'b0;
        r_tseq   = '0;
        case (op_reg)
            OP_SEND:
            begin
                if (stat.can_send)
                begin
                    r_acc    = 1'b1;
                    r_pv     = 1'b1;
                    r_pseq   = stat.next_seq_next - 1'b1;
                    r_ppay   = payload_reg;
                    r_tstart = 1'b1;
                    r_tseq   = stat.next_seq_next - 1'b1;
                end
            end
            OP_ACK:
            begin
                if (ack_ok_reg)
                begin
                    r_tstop = 1'b1;
                    r_tseq  = ack_num_reg;
                end
            end
            OP_TIMEOUT:
            begin
                r_pv     = 1'b1;
                r_pseq   = tseq_reg;
                r_ppay   = ram_rdata;
                r_tstart = 1'b1;
                r_tseq   = tseq_reg;
            end
            default:
            begin
                r_acc = 1'b0;
            end
        endcase
        res = {stat.full_next, stat.next_seq_next, stat.base_next, r_tseq,
               r_tstop, r_tstart, r_ppay, r_pseq, r_pv, r_acc};
    end

    // Result register: load on execute, drop once taken
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (exec_go)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            m_tdata_reg <= OUT_W'(res);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/srsw_checker.sv -----
// Port-level checks of the sender window and their binding to the top level.
`timescale 1ns / 1ps

module srsw_checker #(
    parameter int PAYLOAD_BITS = 64
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((PAYLOAD_BITS+17+7)/8)*8-1:0]  m_tdata
);

    localparam int P = PAYLOAD_BITS;

    // Hold a stalled result item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // An accepted send emits a packet and starts the timer of its own number
    a_send: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |->
            m_tdata[1] && m_tdata[P+5] && (m_tdata[4:2] == m_tdata[P+9:P+7]))
        else $error("accepted send without matching packet and timer start");

    // Never start and stop a timer with one item
    a_timer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[P+5] && m_tdata[P+6]))
        else $error("timer start and stop together");

    // No packet means zero sequence and payload fields
    a_nopkt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> (m_tdata[4:2] == '0) && (m_tdata[P+4:5] == '0))
        else $error("packet fields set without a packet");

    // One item at a time: no input taken while the previous item is still at work
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

endmodule

bind selective_repeat_sender_window_unit srsw_checker #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_srsw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
